[rtl/core/arpc_pkg.sv]
// Package for the action rule priority classifier: field widths, item mode and
// rule kind codes, the structs passed along the cell chain and the kind check.
// No dependencies.
package arpc_pkg;

    localparam int ACCOUNT_W         = 64;
    localparam int NAME_W            = 64;
    localparam int KIND_W            = 2;
    localparam int OFFSET_W          = 16;
    localparam int PRIO_W            = 17;
    localparam int SLOT_W            = 4;
    localparam int TABLE_ENTRIES_DEF = 16;

    // Item mode codes
    localparam logic MODE_RULE   = 1'b0;
    localparam logic MODE_ACTION = 1'b1;

    // Rule kind codes; the fourth code never qualifies
    localparam logic [KIND_W-1:0] KIND_ONLY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ANY   = 2'd2;

    // Rule write broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    slot;
        logic                 enable;
        logic [ACCOUNT_W-1:0] account;
        logic [NAME_W-1:0]    action;
        logic [KIND_W-1:0]    kind;
        logic [OFFSET_W-1:0]  offset;
    } rule_wr_t;

    // Action under classification, held steady during a scan
    typedef struct packed {
        logic [ACCOUNT_W-1:0] account;
        logic [NAME_W-1:0]    action;
        logic                 first;
        logic                 last;
    } query_t;

    // Token handed from cell to cell: best exact and wildcard hits so far
    typedef struct packed {
        logic                valid;
        logic                exact_hit;
        logic [OFFSET_W-1:0] exact_off;
        logic                wild_hit;
        logic [OFFSET_W-1:0] wild_off;
    } hit_t;

    function automatic logic kind_qualifies(input logic [KIND_W-1:0] kind,
                                            input logic first,
                                            input logic last);
        logic q;
        case (kind)
            KIND_ONLY:  q = first & last;
            KIND_FIRST: q = first;
            KIND_ANY:   q = 1'b1;
            default:    q = 1'b0;
        endcase
        return q;
    endfunction

endpackage

[rtl/core/arpc_if.sv]
// Channel interfaces of the action rule priority classifier: action/rule
// items, results and the base priority write channel.
// Depends on arpc_pkg.
interface arpc_item_if;
    logic                           valid;
    logic                           ready;
    logic                           mode;
    logic [arpc_pkg::SLOT_W-1:0]    rule_slot;
    logic                           rule_enable;
    logic [arpc_pkg::ACCOUNT_W-1:0] account_name;
    logic [arpc_pkg::NAME_W-1:0]    act_name;
    logic [arpc_pkg::KIND_W-1:0]    match_kind;
    logic signed [arpc_pkg::OFFSET_W-1:0] priority_offset;
    logic                           last_action;

    modport source (output valid, mode, rule_slot, rule_enable, account_name,
                    act_name, match_kind, priority_offset, last_action,
                    input ready);
    modport sink   (input valid, mode, rule_slot, rule_enable, account_name,
                    act_name, match_kind, priority_offset, last_action,
                    output ready);
endinterface

interface arpc_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [arpc_pkg::PRIO_W-1:0] priority_res;
    logic                               matched;

    modport source (output valid, priority_res, matched, input ready);
    modport sink   (input valid, priority_res, matched, output ready);
endinterface

interface arpc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [arpc_pkg::OFFSET_W-1:0] base_priority;

    modport source (output valid, base_priority, input ready);
    modport sink   (input valid, base_priority, output ready);
endinterface

[rtl/core/arpc_cell.sv]
// One rule cell: holds a table entry, compares it with the broadcast action
// and passes the hit token on to the next cell. Depends on arpc_pkg.
module arpc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  arpc_pkg::rule_wr_t wr,
    input  arpc_pkg::query_t   qry,
    input  arpc_pkg::hit_t     tok_in,
    output arpc_pkg::hit_t     tok_out
);

    logic                           valid_reg;
    logic [arpc_pkg::ACCOUNT_W-1:0] account_reg;
    logic [arpc_pkg::NAME_W-1:0]    action_reg;
    logic [arpc_pkg::KIND_W-1:0]    kind_reg;
    logic [arpc_pkg::OFFSET_W-1:0]  offset_reg;
    arpc_pkg::hit_t                 tok_reg;
    arpc_pkg::hit_t                 tok_next;

    logic wr_here;
    logic acct_ok;
    logic exact;
    logic wild;

    assign wr_here = wr.en && (int'(wr.slot) == CELL_INDEX);

    // Entry storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_here)
        begin
            valid_reg <= wr.enable;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            account_reg <= wr.account;
            action_reg  <= wr.action;
            kind_reg    <= wr.kind;
            offset_reg  <= wr.offset;
        end
    end

    // Compare against the action; lower cells already had their say
    assign acct_ok = valid_reg && (account_reg == qry.account) &&
                     arpc_pkg::kind_qualifies(kind_reg, qry.first, qry.last);
    assign exact   = acct_ok && (action_reg == qry.action);
    assign wild    = acct_ok && (action_reg == '0);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.exact_hit && exact)
        begin
            tok_next.exact_hit = 1'b1;
            tok_next.exact_off = offset_reg;
        end
        if (!tok_in.wild_hit && wild)
        begin
            tok_next.wild_hit = 1'b1;
            tok_next.wild_off = offset_reg;
        end
    end

    // Token hand-over to the neighbour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/core/action_rule_priority_classifier.sv]
// Action rule priority classifier, top level. Rule cells in a chain plus the
// transaction sequencer. Depends on arpc_pkg, arpc_if and arpc_cell.
//
// Rule writes (mode 0) land in the cell picked by rule_slot. An action
// (mode 1) of an undecided transaction sends a token down the row of
// TABLE_ENTRIES rule cells, one cell per cycle, collecting the lowest exact
// hit and the lowest wildcard hit in one pass; the next item is taken only
// once the token has left the end of the cell chain and the sequencer has
// passed its done state. Actions of an already decided transaction start no
// scan. A result sits in an output register, so the next item is accepted
// while it waits to be taken; a following result waits for that register to
// drain. The table is empty after reset.
module action_rule_priority_classifier #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input logic           clk,
    input logic           rst_n,
    arpc_item_if.sink     item,
    arpc_result_if.source result,
    arpc_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [arpc_pkg::OFFSET_W-1:0] base_reg;
    logic                          at_first_reg;
    logic                          decided_reg;
    logic                          launch_reg;
    arpc_pkg::query_t              qry_reg;

    logic                          pend_emit_reg;
    logic                          pend_matched_reg;
    logic [arpc_pkg::PRIO_W-1:0]   pend_prio_reg;

    logic                          out_valid_reg;
    logic [arpc_pkg::PRIO_W-1:0]   out_prio_reg;
    logic                          out_matched_reg;

    arpc_pkg::rule_wr_t            wr;
    arpc_pkg::hit_t                tok [0:TABLE_ENTRIES];
    arpc_pkg::hit_t                tail;

    logic                          item_acc;
    logic                          act_acc;
    logic                          out_free;
    logic                          any_hit;
    logic [arpc_pkg::OFFSET_W-1:0] hit_off;
    logic [arpc_pkg::PRIO_W-1:0]   sum_prio;
    logic [arpc_pkg::PRIO_W-1:0]   base_ext;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign act_acc    = item_acc && (item.mode == arpc_pkg::MODE_ACTION);
    assign out_free   = !out_valid_reg || result.ready;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg.valid)
        begin
            base_reg <= cfg.base_priority;
        end
    end

    // Rule write broadcast
    always_comb
    begin
        wr.en      = item_acc && (item.mode == arpc_pkg::MODE_RULE);
        wr.slot    = item.rule_slot;
        wr.enable  = item.rule_enable;
        wr.account = item.account_name;
        wr.action  = item.act_name;
        wr.kind    = item.match_kind;
        wr.offset  = item.priority_offset;
    end

    // Cell chain
    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = launch_reg;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        arpc_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .qry     (qry_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign tail = tok[TABLE_ENTRIES];

    // Result of the scan: exact hit wins over wildcard
    assign any_hit  = tail.exact_hit || tail.wild_hit;
    assign hit_off  = tail.exact_hit ? tail.exact_off : tail.wild_off;
    assign base_ext = {base_reg[arpc_pkg::OFFSET_W-1], base_reg};
    assign sum_prio = base_ext + {hit_off[arpc_pkg::OFFSET_W-1], hit_off};

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (act_acc && !decided_reg)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!pend_emit_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            at_first_reg <= 1'b1;
            decided_reg  <= 1'b0;
            launch_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= act_acc && !decided_reg;
            if (act_acc)
            begin
                at_first_reg <= item.last_action;
                if (decided_reg && item.last_action)
                begin
                    decided_reg <= 1'b0;
                end
            end
            if (state_reg == ST_SCAN && tail.valid)
            begin
                decided_reg <= any_hit && !qry_reg.last;
            end
        end
    end

    // Action held for the scan
    always_ff @(posedge clk)
    begin
        if (act_acc && !decided_reg)
        begin
            qry_reg.account <= item.account_name;
            qry_reg.action  <= item.act_name;
            qry_reg.first   <= at_first_reg;
            qry_reg.last    <= item.last_action;
        end
    end

    // Pending result from the scan
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && tail.valid)
        begin
            pend_emit_reg    <= any_hit || qry_reg.last;
            pend_matched_reg <= any_hit;
            pend_prio_reg    <= any_hit ? sum_prio : base_ext;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && pend_emit_reg && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && pend_emit_reg && out_free)
        begin
            out_prio_reg    <= pend_prio_reg;
            out_matched_reg <= pend_matched_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.priority_res = out_prio_reg;
    assign result.matched      = out_matched_reg;

endmodule
